FILE: sv/aais_pkg.sv
// Shared constants, types and helpers for the area-averaging image scaler.
`default_nettype none
package aais_pkg;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LINE_W     = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + LINE_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int SIZE_W     = 9;
  localparam int CW         = 18;   // common-axis coordinates and sums
  localparam int LANES      = 3;
  localparam int CNT_W      = $clog2(CW + 1);

  typedef enum logic [7:0] {
    REG_SOURCE_WIDTH  = 8'd0,
    REG_SOURCE_HEIGHT = 8'd1,
    REG_TARGET_WIDTH  = 8'd2,
    REG_TARGET_HEIGHT = 8'd3
  } reg_index_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: sv/area_average_image_scaler.sv
// Area-averaging RGB scaler: frame store, window walk and divider control.
//
// Channel | Signals                                        | Direction
// in      | in_valid/in_ready, operation, column, line, rgb | into block
// out     | out_valid/out_ready, red/green/blue_out         | out of block
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data        | into block
//
// A load writes the frame store at acceptance.
// A request walks the source rows and columns its window covers; each pass of
// the shared divider runs 18 quotient steps between start and claim, and each
// source pixel takes a read state and an accumulate state, as the frame store
// read is registered.
// A request outside the target picture goes straight to finish with a zero result.
// Reset clears control state and sets the four size registers to 256; the frame store is undefined until loaded.
// A waiting result does not block acceptance; a finished result waits for out.
`default_nettype none
module area_average_image_scaler
  import aais_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              operation,
  input  wire logic [7:0]        column,
  input  wire logic [7:0]        line,
  input  wire logic [7:0]        red_in,
  input  wire logic [7:0]        green_in,
  input  wire logic [7:0]        blue_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        red_out,
  output logic      [7:0]        green_out,
  output logic      [7:0]        blue_out,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_index,
  input  wire logic [8:0]        cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_DIV_WAIT, S_ROW_INIT, S_H_RD, S_H_ACC, S_H_DIV,
    S_V_DIV, S_FINISH
  } state_t;

  state_t state;

  logic [SIZE_W-1:0] source_width, source_height, target_width, target_height;
  logic [SIZE_W-1:0] sw, sh, tw, th;
  logic [COL_W-1:0]  req_col, kcol;
  logic [LINE_W-1:0] req_line, rrow;
  logic [CW-1:0]     x0, x1, y0, y1, kpos, rpos, kstart;
  logic [COL_W-1:0]  k0;
  logic [SIZE_W-1:0] ox;
  logic [CW-1:0]     hacc [LANES];
  logic [CW-1:0]     vacc [LANES];
  logic [7:0]        res  [LANES];
  logic              div_start;

  logic [23:0]       frame [DEPTH];
  logic [23:0]       rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  logic [CW-1:0]     div_dividend [LANES];
  logic [SIZE_W-1:0] div_divisor  [LANES];
  div_stat_t         div_stat;
  logic [CW-1:0]     div_quot [LANES];
  logic [SIZE_W-1:0] div_rem  [LANES];

  logic [CW-1:0] kend, klo, khi, rend, rlo, rhi, ox_w, oy_w;
  logic [SIZE_W-1:0] oy;
  logic [7:0] pix [LANES];

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SIZE_W'(256);
      source_height <= SIZE_W'(256);
      target_width  <= SIZE_W'(256);
      target_height <= SIZE_W'(256);
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_TARGET_WIDTH:  target_width  <= cfg_data;
        REG_TARGET_HEIGHT: target_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame store
  assign wr_en   = in_valid && in_ready && (op_t'(operation) == OP_LOAD);
  assign wr_addr = {line[LINE_W-1:0], column[COL_W-1:0]};
  assign rd_addr = {rrow, kcol};
  always_ff @(posedge clk) begin
    if (wr_en) frame[wr_addr] <= {red_in, green_in, blue_in};
    rd_data <= frame[rd_addr];
  end
  assign pix[0] = rd_data[23:16];
  assign pix[1] = rd_data[15:8];
  assign pix[2] = rd_data[7:0];

  // overlap of the current source span with the target span
  assign kend = kpos + CW'(tw);
  assign klo  = (kpos > x0) ? kpos : x0;
  assign khi  = (kend < x1) ? kend : x1;
  assign ox_w = khi - klo;
  assign rend = rpos + CW'(th);
  assign rlo  = (rpos > y0) ? rpos : y0;
  assign rhi  = (rend < y1) ? rend : y1;
  assign oy_w = rhi - rlo;
  assign oy   = oy_w[SIZE_W-1:0];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      div_dividend[i] = '0;
      div_divisor[i]  = SIZE_W'(1);
    end
    case (state)
      S_DIV_WAIT: begin
        div_dividend[0] = x0;
        div_divisor[0]  = tw;
        div_dividend[1] = y0;
        div_divisor[1]  = th;
      end
      S_H_DIV: begin
        for (int i = 0; i < LANES; i++) begin
          div_dividend[i] = hacc[i];
          div_divisor[i]  = sw;
        end
      end
      S_V_DIV: begin
        for (int i = 0; i < LANES; i++) begin
          div_dividend[i] = vacc[i];
          div_divisor[i]  = sh;
        end
      end
      default: ;
    endcase
  end

  aais_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      // start the divider for the window bounds, each row sum and the final sum
      div_start <= (state == S_SETUP) ||
                   (state == S_H_ACC && !(kend < x1)) ||
                   (state == S_H_DIV && div_stat.done && !(rend < y1));
      if (out_valid && out_ready && state != S_FINISH) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && op_t'(operation) == OP_REQUEST) begin
            req_col  <= column[COL_W-1:0];
            req_line <= line[LINE_W-1:0];
            sw <= clamp_size(source_width,  SIZE_W'(MAX_WIDTH));
            sh <= clamp_size(source_height, SIZE_W'(MAX_HEIGHT));
            tw <= clamp_size(target_width,  SIZE_W'(MAX_WIDTH));
            th <= clamp_size(target_height, SIZE_W'(MAX_HEIGHT));
            if ({1'b0, column} >= clamp_size(target_width, SIZE_W'(MAX_WIDTH)) ||
                {1'b0, line} >= clamp_size(target_height, SIZE_W'(MAX_HEIGHT))) begin
              for (int i = 0; i < LANES; i++) res[i] <= '0;
              state <= S_FINISH;
            end else begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          x0 <= CW'(req_col) * CW'(sw);
          x1 <= CW'(req_col) * CW'(sw) + CW'(sw);
          y0 <= CW'(req_line) * CW'(sh);
          y1 <= CW'(req_line) * CW'(sh) + CW'(sh);
          for (int i = 0; i < LANES; i++) vacc[i] <= '0;
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            k0     <= div_quot[0][COL_W-1:0];
            kstart <= x0 - CW'(div_rem[0]);
            rrow   <= div_quot[1][LINE_W-1:0];
            rpos   <= y0 - CW'(div_rem[1]);
            state  <= S_ROW_INIT;
          end
        end
        S_ROW_INIT: begin
          kcol <= k0;
          kpos <= kstart;
          for (int i = 0; i < LANES; i++) hacc[i] <= '0;
          state <= S_H_RD;
        end
        S_H_RD: begin
          ox    <= ox_w[SIZE_W-1:0];
          state <= S_H_ACC;
        end
        S_H_ACC: begin
          for (int i = 0; i < LANES; i++) hacc[i] <= hacc[i] + CW'(pix[i]) * CW'(ox);
          kcol <= kcol + COL_W'(1);
          kpos <= kend;
          if (kend < x1) begin
            state <= S_H_RD;
          end else begin
            state <= S_H_DIV;
          end
        end
        S_H_DIV: begin
          if (div_stat.done) begin
            for (int i = 0; i < LANES; i++)
              vacc[i] <= vacc[i] + CW'(div_quot[i][7:0]) * CW'(oy);
            rrow <= rrow + LINE_W'(1);
            rpos <= rend;
            if (rend < y1) begin
              state <= S_ROW_INIT;
            end else begin
              state <= S_V_DIV;
            end
          end
        end
        S_V_DIV: begin
          if (div_stat.done) begin
            for (int i = 0; i < LANES; i++) res[i] <= div_quot[i][7:0];
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold the result until the output register frees
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            red_out   <= res[0];
            green_out <= res[1];
            blue_out  <= res[2];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_stat.busy) else $error("input taken while divider runs");
  a_acc_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_H_ACC |-> $past(state) == S_H_RD) else $error("accumulate without read");
  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV_WAIT || state == S_H_DIV || state == S_V_DIV)
    else $error("divider result unclaimed");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == S_IDLE) else $error("store written during request");
endmodule
`default_nettype wire

FILE: sv/aais_divider.sv
// Three-lane restoring divider, one quotient bit per cycle.
`default_nettype none
module aais_divider
  import aais_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [CW-1:0]         dividend [LANES],
  input  wire logic [SIZE_W-1:0]     divisor  [LANES],
  output div_stat_t                  stat,
  output logic      [CW-1:0]         quot     [LANES],
  output logic      [SIZE_W-1:0]     rem      [LANES]
);
  logic [SIZE_W-1:0] dsr [LANES];
  logic [CNT_W-1:0]  cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(CW);
      end else if (stat.busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [SIZE_W:0] trial;
    assign trial = {rem[g], quot[g][CW-1]};
    always_ff @(posedge clk) begin
      if (start) begin
        quot[g] <= dividend[g];
        rem[g]  <= '0;
        dsr[g]  <= divisor[g];
      end else if (stat.busy) begin
        if (trial >= {1'b0, dsr[g]}) begin
          rem[g]  <= SIZE_W'(trial - {1'b0, dsr[g]});
          quot[g] <= {quot[g][CW-2:0], 1'b1};
        end else begin
          rem[g]  <= trial[SIZE_W-1:0];
          quot[g] <= {quot[g][CW-2:0], 1'b0};
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !stat.busy) else $error("divider restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> $past(stat.busy) && !stat.busy) else $error("done without run");
  a_cnt_busy: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> cnt != '0) else $error("busy with zero count");
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the area-averaging image scaler.
`timescale 1ns / 100ps
`default_nettype none
module tb_top
  import aais_pkg::*;
();

  localparam logic [7:0] REG_UNUSED = 8'd200;  // index with no register behind it
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [8:0] sw;
    logic [8:0] sh;
    logic [8:0] tw;
    logic [8:0] th;
    int         items;
  } phase_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] col;
    logic [7:0] ln;
    logic [23:0] rgb;
    logic       has_rgb;  // typed expectation present
    logic [23:0] want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = 1'b0;
  logic [7:0] column = '0;
  logic [7:0] line = '0;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  area_average_image_scaler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .column(column), .line(line),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block's state
  logic [23:0] frame_copy [DEPTH];
  logic [8:0] src_w_reg = 9'd256, src_h_reg = 9'd256;
  logic [8:0] tgt_w_reg = 9'd256, tgt_h_reg = 9'd256;

  logic [23:0] pixel_queue [$];
  int idle_mode = 0;
  int hold_requests = 0;
  int errors = 0;
  int loads_sent = 0, requests_sent = 0, pixels_seen = 0;

  function automatic int eff_size(input logic [8:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int overlap(input int a0, input int a1, input int b0, input int b1);
    int lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // Separable area average of one target pixel
  function automatic logic [23:0] scaled_pixel(input int col, input int ln);
    int sw, sh, tw, th, x0, x1, y0, y1, oy, ox, c;
    int hsum [3];
    int vsum [3];
    logic [23:0] px, res;
    sw = eff_size(src_w_reg, MAX_WIDTH);
    sh = eff_size(src_h_reg, MAX_HEIGHT);
    tw = eff_size(tgt_w_reg, MAX_WIDTH);
    th = eff_size(tgt_h_reg, MAX_HEIGHT);
    res = '0;
    if (col >= tw || ln >= th) return res;
    x0 = col * sw; x1 = (col + 1) * sw;
    y0 = ln * sh;  y1 = (ln + 1) * sh;
    vsum = '{0, 0, 0};
    for (int r = y0 / th; r <= (y1 - 1) / th; r++) begin
      oy = overlap(y0, y1, r * th, (r + 1) * th);
      hsum = '{0, 0, 0};
      for (int k = x0 / tw; k <= (x1 - 1) / tw; k++) begin
        ox = overlap(x0, x1, k * tw, (k + 1) * tw);
        px = frame_copy[r * MAX_WIDTH + k];
        for (c = 0; c < 3; c++) hsum[c] += int'(px[23 - 8*c -: 8]) * ox;
      end
      for (c = 0; c < 3; c++) vsum[c] += ((hsum[c] / sw) & 255) * oy;
    end
    for (c = 0; c < 3; c++) res[23 - 8*c -: 8] = 8'((vsum[c] / sh) & 255);
    return res;
  endfunction

  // Offer one transaction, idling first if the phase asks for it
  task automatic send(input op_t op, input logic [7:0] col, input logic [7:0] ln,
                      input logic [23:0] rgb, input logic typed,
                      input logic [23:0] want);
    while ((idle_mode == 1 && $urandom_range(99) < 46) ||
           (idle_mode == 3 && $urandom_range(99) < 21)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    column <= col;
    line <= ln;
    {red_in, green_in, blue_in} <= rgb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_LOAD) begin
      frame_copy[{ln, col}] = rgb;
      loads_sent++;
    end else begin
      pixel_queue.push_back(typed ? want : scaled_pixel(col, ln));
      requests_sent++;
    end
  endtask

  // Offer one register write; the caller drops cfg_valid after the last one
  task automatic write_reg(input logic [7:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SOURCE_WIDTH:  src_w_reg = val;
      REG_SOURCE_HEIGHT: src_h_reg = val;
      REG_TARGET_WIDTH:  tgt_w_reg = val;
      REG_TARGET_HEIGHT: tgt_h_reg = val;
      default: ;
    endcase
  endtask

  // Drain results, then let a trailing load settle before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stall, long hold-off on request, and checking
  int hold_left = 0, hold_seen = 0;
  always @(posedge clk) begin
    logic [23:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        pixels_seen++;
        if (pixel_queue.size() == 0) begin
          $display("%0t: unexpected pixel %h%h%h", $time, red_out, green_out, blue_out);
          errors++;
        end else begin
          want = pixel_queue.pop_front();
          if (red_out !== want[23:16]) begin
            $display("%0t: red expected %h actual %h", $time, want[23:16], red_out);
            errors++;
          end
          if (green_out !== want[15:8]) begin
            $display("%0t: green expected %h actual %h", $time, want[15:8], green_out);
            errors++;
          end
          if (blue_out !== want[7:0]) begin
            $display("%0t: blue expected %h actual %h", $time, want[7:0], blue_out);
            errors++;
          end
        end
      end
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !((idle_mode == 2 && $urandom_range(99) < 46) ||
                       (idle_mode == 3 && $urandom_range(99) < 21));
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("area_average_image_scaler test failed");
      $finish;
    end
  end

  row_t directed [8] = '{
    '{OP_LOAD,    8'd0,   8'd0,   24'hff0080, 1'b0, 24'h0},
    '{OP_LOAD,    8'd255, 8'd255, 24'h01feff, 1'b0, 24'h0},
    '{OP_LOAD,    8'd0,   8'd255, 24'hffffff, 1'b0, 24'h0},
    '{OP_LOAD,    8'd255, 8'd0,   24'h000000, 1'b0, 24'h0},
    '{OP_REQUEST, 8'd0,   8'd0,   24'h0,      1'b1, 24'hff0080},
    '{OP_REQUEST, 8'd255, 8'd255, 24'h0,      1'b1, 24'h01feff},
    '{OP_REQUEST, 8'd0,   8'd255, 24'h0,      1'b1, 24'hffffff},
    '{OP_REQUEST, 8'd255, 8'd0,   24'h0,      1'b1, 24'h000000}
  };

  phase_t phases [11];

  initial begin
    int sw, sh, tw, th, pick, col, ln;
    phases[0] = '{9'd3, 9'd2, 9'd7, 9'd5, 20};
    phases[1] = '{9'd8, 9'd8, 9'd3, 9'd3, 20};
    phases[2] = '{9'd0, 9'd0, 9'd0, 9'd0, 12};
    phases[3] = '{9'd100, 9'd1, 9'd1, 9'd511, 10};
    phases[4] = '{9'd5, 9'd7, 9'd5, 9'd7, 20};
    for (int p = 5; p < 11; p++)
      phases[p] = '{9'($urandom_range(6, 1)), 9'($urandom_range(6, 1)),
                    9'($urandom_range(12, 1)), 9'($urandom_range(12, 1)), 8};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send(directed[i].op, directed[i].col, directed[i].ln, directed[i].rgb,
           directed[i].has_rgb, directed[i].want);
    wait_idle();

    foreach (phases[p]) begin
      idle_mode = p % 4;
      write_reg(REG_SOURCE_WIDTH, phases[p].sw);
      write_reg(REG_SOURCE_HEIGHT, phases[p].sh);
      write_reg(REG_TARGET_WIDTH, phases[p].tw);
      write_reg(REG_TARGET_HEIGHT, phases[p].th);
      if (p == 2) write_reg(REG_UNUSED, 9'd5);  // must leave all sizes alone
      cfg_valid <= 1'b0;
      sw = eff_size(src_w_reg, MAX_WIDTH);
      sh = eff_size(src_h_reg, MAX_HEIGHT);
      tw = eff_size(tgt_w_reg, MAX_WIDTH);
      th = eff_size(tgt_h_reg, MAX_HEIGHT);
      // fill the whole source picture so no window reads an unloaded entry
      for (int y = 0; y < sh; y++)
        for (int x = 0; x < sw; x++)
          send(OP_LOAD, 8'(x), 8'(y), 24'($urandom()), 1'b0, 24'h0);
      if (p == 1) hold_requests++;
      for (int n = 0; n < phases[p].items; n++) begin
        pick = $urandom_range(99);
        if (pick < 20) begin
          send(OP_LOAD, 8'($urandom_range(sw - 1)), 8'($urandom_range(sh - 1)),
               24'($urandom()), 1'b0, 24'h0);
        end else if (pick < 35) begin
          send(OP_LOAD, 8'($urandom()), 8'($urandom()), 24'($urandom()), 1'b0, 24'h0);
        end else begin
          if (pick < 80) begin
            col = $urandom_range(tw - 1);
            ln = $urandom_range(th - 1);
          end else if (pick < 92) begin
            col = $urandom_range(tw + 1);
            ln = $urandom_range(th + 1);
          end else begin
            col = $urandom_range(255);
            ln = $urandom_range(255);
          end
          send(OP_REQUEST, 8'(col), 8'(ln), 24'($urandom()), 1'b0, 24'h0);
        end
      end
      wait_idle();
    end

    repeat (50) @(posedge clk);
    $display("Covered %0d loads and %0d requests over %0d size settings; %0d pixels checked.",
             loads_sent, requests_sent, $size(phases) + 1, pixels_seen);
    if (errors == 0 && pixel_queue.size() == 0)
      $display("area_average_image_scaler test passed");
    else
      $display("area_average_image_scaler test failed");
    $finish;
  end
endmodule
`default_nettype wire

FILE: area_average_image_scaler.f
sv/aais_pkg.sv
sv/aais_divider.sv
sv/area_average_image_scaler.sv
test/tb_top.sv
